// File: hdl/ple_pkg.sv
// Shared types, sizes and codes for the positional list engine.
package ple_pkg;

	// Store geometry.
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);

	// Field widths of the command and result transactions.
	localparam int CMD_W   = 2;
	localparam int POS_W   = 5;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_ZERO  = 2'd3;

	// One command transaction.
	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] data_word;
	} ple_req_t;

	// One result transaction.
	typedef struct packed {
		logic [WORD_W-1:0]  result_word;
		logic               word_valid;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] entry_count;
	} ple_rsp_t;

	// Controller to datapath command group.
	typedef struct packed {
		logic                  load;
		logic                  do_insert;
		logic                  do_remove;
		logic                  word_valid;
		logic [STAT_W-1:0]     status;
		logic [IDX_W-1:0]      idx;
		logic [DATA_WIDTH-1:0] word;
		logic [COUNT_W-1:0]    next_count;
	} ple_op_t;

endpackage

// File: hdl/ple_ctrl.sv
// Controller: accepts a command, checks it against the fill count and drives the datapath.
module ple_ctrl import ple_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ple_req_t           request,
	input  logic [COUNT_W-1:0] count,
	output logic               busy,
	output logic               done,
	output ple_op_t            op
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic                  state_q;
	logic                  done_q;
	ple_req_t              req_q;
	logic                  accept;
	logic [DATA_WIDTH-1:0] word_m;
	logic                  word_zero;

	assign accept = start && (state_q == S_IDLE);

	// Sequencer: takes the command in the idle state and applies it in the execute state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The command transaction is held while it executes.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	assign word_m    = DATA_WIDTH'(req_q.data_word);
	assign word_zero = (word_m == '0);

	// Decode and range checks, in the order that decides the status.
	always_comb begin
		op            = '0;
		op.load       = (state_q == S_EXEC);
		op.idx        = req_q.position[IDX_W-1:0];
		op.word       = word_m;
		op.next_count = count;
		op.status     = ST_OK;
		unique case (req_q.command)
			CMD_INSERT: begin
				if (word_zero) begin
					op.status = ST_ZERO;
				end else if (req_q.position > count) begin
					op.status = ST_RANGE;
				end else if (count >= COUNT_W'(CAPACITY)) begin
					op.status = ST_FULL;
				end else begin
					op.do_insert  = op.load;
					op.next_count = count + COUNT_W'(1);
				end
			end
			CMD_REMOVE, CMD_READ: begin
				if (req_q.position >= count) begin
					op.status = ST_RANGE;
				end else begin
					op.word_valid = 1'b1;
					if (req_q.command == CMD_REMOVE) begin
						op.do_remove  = op.load;
						op.next_count = count - COUNT_W'(1);
					end
				end
			end
			CMD_CLEAR: begin
				op.next_count = '0;
			end
			default: op.status = ST_OK;
		endcase
	end

	assign busy = (state_q == S_EXEC);
	assign done = done_q;

endmodule

// File: hdl/ple_datapath.sv
// Datapath: shift-capable row of word cells, fill count and result register.
module ple_datapath import ple_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ple_op_t            op,
	output logic [COUNT_W-1:0] count,
	output ple_rsp_t           result
);

	logic [DATA_WIDTH-1:0] row_q [CAPACITY];
	logic [COUNT_W-1:0]    count_q;
	ple_rsp_t              rsp_q;

	// Cells past idx take the left cell on insert; from idx, the right cell on remove.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (op.do_insert) begin
				if (IDX_W'(i) == op.idx) begin
					row_q[i] <= op.word;
				end else if (IDX_W'(i) > op.idx) begin
					if (i > 0) row_q[i] <= row_q[(i > 0) ? i - 1 : 0];
				end
			end else if (op.do_remove) begin
				if ((IDX_W'(i) >= op.idx) && (i < CAPACITY - 1)) begin
					row_q[i] <= row_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.load) begin
			count_q <= op.next_count;
		end
	end

	// Result capture: the addressed word is read before any shift lands.
	always_ff @(posedge clk) begin
		if (op.load) begin
			rsp_q.result_word <= op.word_valid ? WORD_W'(row_q[op.idx]) : '0;
			rsp_q.word_valid  <= op.word_valid;
			rsp_q.status      <= op.status;
			rsp_q.entry_count <= op.next_count;
		end
	end

	assign count  = count_q;
	assign result = rsp_q;

endmodule

// File: hdl/positional_list_engine.sv
// Top level of the positional list engine: controller and datapath.
// A command is taken at a rising edge with start high and busy low; busy then
// stays high for one cycle while the command is applied to the row of cells,
// and the result appears with done high in the following cycle, for exactly
// one cycle, and cannot be held off. A new command may be started in the cycle
// that shows the previous result, but not while busy is high. Every command,
// including a rejected one, gives exactly one result. No clearing pass follows reset.
module positional_list_engine import ple_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ple_req_t request,
	output logic     busy,
	output logic     done,
	output ple_rsp_t result
);

	ple_op_t            op;
	logic [COUNT_W-1:0] count;

	ple_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.count   (count),
		.busy    (busy),
		.done    (done),
		.op      (op)
	);

	ple_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.count  (count),
		.result (result)
	);

endmodule

// File: hdl/ple_checker.sv
// Port-level checks of the positional list engine, bound to the top level.
module ple_checker import ple_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input ple_req_t request,
	input logic     busy,
	input logic     done,
	input ple_rsp_t result
);

	// A taken command makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not follow an accepted transaction");

	// Each busy cycle is followed by exactly one result.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("result did not follow execution");

	// A result only appears right after execution.
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction");

	// A result without a word carries zero, and a failed command carries no word.
	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (!result.word_valid || (result.status != ST_OK)))
			|-> (!result.word_valid && (result.result_word == '0)))
		else $error("stray result word");

	// The reported count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.entry_count <= COUNT_W'(CAPACITY)))
		else $error("entry count beyond capacity");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

// File: verif/positional_list_engine_test.sv
// Self-checking testbench for the positional list engine with a scoreboard that tracks the list.
module positional_list_engine_test import ple_pkg::*; ();

	// Tracks the list contents and the results the engine owes.
	class list_tracker;
		logic [DATA_WIDTH-1:0] cells [CAPACITY];
		int                    fill;
		ple_rsp_t              owed_results [$];
		int                    failures;

		function new();
			fill = 0;
			failures = 0;
			foreach (cells[i])
				cells[i] = '0;
		endfunction

		// Apply one accepted command to the tracked list and queue its result.
		function void note_command(ple_req_t req);
			logic [WORD_W-1:0] mask;
			logic [WORD_W-1:0] w;
			ple_rsp_t          rsp;
			int                pos;
			mask = '1;
			mask = mask >> (WORD_W - DATA_WIDTH);
			w = req.data_word & mask;
			pos = int'(req.position);
			rsp = '0;
			rsp.status = ST_OK;
			case (req.command)
				CMD_INSERT: begin
					// The zero-word check wins over the range and full checks.
					if (w == '0) begin
						rsp.status = ST_ZERO;
					end else if (pos > fill) begin
						rsp.status = ST_RANGE;
					end else if (fill >= CAPACITY) begin
						rsp.status = ST_FULL;
					end else begin
						for (int i = fill; i > pos; i--)
							cells[i] = cells[i-1];
						cells[pos] = w[DATA_WIDTH-1:0];
						fill++;
					end
				end
				CMD_REMOVE, CMD_READ: begin
					if (pos >= fill) begin
						rsp.status = ST_RANGE;
					end else begin
						rsp.result_word = WORD_W'(cells[pos]);
						rsp.word_valid = 1'b1;
						if (req.command == CMD_REMOVE) begin
							for (int i = pos; i + 1 < fill; i++)
								cells[i] = cells[i+1];
							fill--;
						end
					end
				end
				default: begin
					fill = 0;
				end
			endcase
			rsp.entry_count = COUNT_W'(fill);
			owed_results.push_back(rsp);
		endfunction

		// Compare one result from the engine with the oldest owed result.
		function void check_result(ple_rsp_t got);
			ple_rsp_t want;
			if (owed_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result transaction: word=%h valid=%b status=%0d count=%0d",
						got.result_word, got.word_valid, got.status, got.entry_count);
				return;
			end
			want = owed_results.pop_front();
			if (got.result_word !== want.result_word || got.word_valid !== want.word_valid ||
			    got.status !== want.status || got.entry_count !== want.entry_count) begin
				failures++;
				if (failures <= 10) begin
					$display("result mismatch: expected word=%h valid=%b status=%0d count=%0d",
						want.result_word, want.word_valid, want.status, want.entry_count);
					$display("                 got      word=%h valid=%b status=%0d count=%0d",
						got.result_word, got.word_valid, got.status, got.entry_count);
				end
			end
		endfunction

		function int owed();
			return owed_results.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	ple_req_t request;
	logic     busy;
	logic     done;
	ple_rsp_t result;

	list_tracker tracker = new();

	positional_list_engine uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Check every result transaction in the cycle it is shown.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			tracker.check_result(result);
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic ple_req_t make_command(logic [CMD_W-1:0] cmd, int pos,
						  logic [WORD_W-1:0] word);
		ple_req_t req;
		req.command = cmd;
		req.position = POS_W'(pos);
		req.data_word = word;
		return req;
	endfunction

	// Data words that favor zero, all ones and single bits now and then.
	function automatic logic [WORD_W-1:0] random_word();
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 5)
			return '0;
		else if (pick < 8)
			return '1;
		else if (pick < 11)
			return WORD_W'(1) << $urandom_range(WORD_W - 1, 0);
		else
			return $urandom;
	endfunction

	// A command shaped by the current list length; most positions are legal.
	function automatic ple_req_t random_command(int ins_pct, int rem_pct, int rd_pct);
		ple_req_t req;
		int       pick;
		int       fill;
		fill = tracker.fill;
		pick = $urandom_range(99, 0);
		if (pick < ins_pct)
			req.command = CMD_INSERT;
		else if (pick < ins_pct + rem_pct)
			req.command = CMD_REMOVE;
		else if (pick < ins_pct + rem_pct + rd_pct)
			req.command = CMD_READ;
		else
			req.command = CMD_CLEAR;
		if ($urandom_range(99, 0) < 15)
			req.position = POS_W'($urandom_range((1 << POS_W) - 1, 0));
		else if (req.command == CMD_INSERT)
			req.position = POS_W'($urandom_range(fill, 0));
		else
			req.position = POS_W'((fill > 0) ? $urandom_range(fill - 1, 0) : 0);
		req.data_word = random_word();
		return req;
	endfunction

	// Present one command from a falling edge and hold it until it is taken.
	task automatic send_command(ple_req_t req);
		start <= 1'b1;
		request <= req;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_command(req);
		@(negedge clk);
	endtask

	// Leave the engine idle for a number of cycles with noise on the request.
	task automatic idle_for(int cycles);
		for (int i = 0; i < cycles; i++) begin
			if (i == 0)
				start <= 1'b0;
			request <= $bits(ple_req_t)'({$urandom, $urandom});
			@(negedge clk);
		end
	endtask

	initial begin
		ple_req_t directed [$];
		ple_req_t req;
		int       sent;
		int       burst_left;
		int       seg_left;
		int       mode;
		int       ins_pct;
		int       rem_pct;
		int       rd_pct;
		int       guard;

		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed commands: empty store, priorities, head, tail, middle, draining.
		directed.push_back(make_command(CMD_READ, 0, 32'h0000_0000));
		directed.push_back(make_command(CMD_REMOVE, 0, 32'hFFFF_FFFF));
		directed.push_back(make_command(CMD_INSERT, 1, 32'h0000_0005));
		directed.push_back(make_command(CMD_INSERT, 31, 32'h0000_0000));
		directed.push_back(make_command(CMD_INSERT, 0, 32'hFFFF_FFFF));
		directed.push_back(make_command(CMD_INSERT, 1, 32'h0000_0001));
		directed.push_back(make_command(CMD_INSERT, 0, 32'h8000_0000));
		directed.push_back(make_command(CMD_INSERT, 2, 32'h1234_5678));
		directed.push_back(make_command(CMD_INSERT, 5, 32'hAAAA_AAAA));
		directed.push_back(make_command(CMD_READ, 0, 32'h0));
		directed.push_back(make_command(CMD_READ, 3, 32'h0));
		directed.push_back(make_command(CMD_READ, 4, 32'h0));
		directed.push_back(make_command(CMD_READ, 31, 32'h0));
		directed.push_back(make_command(CMD_REMOVE, 3, 32'h0));
		directed.push_back(make_command(CMD_REMOVE, 0, 32'h0));
		directed.push_back(make_command(CMD_REMOVE, 1, 32'h0));
		directed.push_back(make_command(CMD_REMOVE, 0, 32'h0));
		directed.push_back(make_command(CMD_READ, 0, 32'h0));
		directed.push_back(make_command(CMD_REMOVE, 0, 32'h0));
		directed.push_back(make_command(CMD_INSERT, 0, 32'h5555_5555));
		directed.push_back(make_command(CMD_CLEAR, 21, 32'hDEAD_BEEF));
		directed.push_back(make_command(CMD_READ, 0, 32'h0));
		directed.push_back(make_command(CMD_INSERT, 16, 32'h0000_0001));
		foreach (directed[i]) begin
			send_command(directed[i]);
			if (i % 5 == 4)
				idle_for($urandom_range(3, 1));
		end

		// Random segments that grow, drain or mix the list, sent in bursts.
		sent = 0;
		burst_left = 0;
		seg_left = 0;
		ins_pct = 35;
		rem_pct = 30;
		rd_pct = 32;
		while (sent < 1400) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(120, 20);
				mode = $urandom_range(2, 0);
				case (mode)
					0: begin
						ins_pct = 72; rem_pct = 12; rd_pct = 14;
					end
					1: begin
						ins_pct = 15; rem_pct = 65; rd_pct = 18;
					end
					default: begin
						ins_pct = 35; rem_pct = 30; rd_pct = 32;
					end
				endcase
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(30, 1);
				if ($urandom_range(3, 0) != 0)
					idle_for($urandom_range(6, 1));
			end
			req = random_command(ins_pct, rem_pct, rd_pct);
			send_command(req);
			sent++;
			burst_left--;
			seg_left--;
		end
		start <= 1'b0;

		// Let the remaining results drain.
		guard = 0;
		while (tracker.owed() > 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		tracker.failures += tracker.owed();

		if (tracker.failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: positional_list_engine.f
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_datapath.sv
hdl/positional_list_engine.sv
hdl/ple_checker.sv
verif/positional_list_engine_test.sv
